### sv/srpg_pkg.sv
package srpg_pkg;

  localparam int POSITION_BITS_DEF   = 32;
  localparam int DELAY_FRAC_BITS_DEF = 16;

  localparam int FUNC_W  = 2;
  localparam int MM_W    = 16;
  localparam int SPM_W   = 16;
  localparam int RAMP_W  = 16;
  localparam int DELAY_W = 32;
  localparam int RINV_W  = 17;
  localparam int OUTPOS_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_HOME = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_MM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEPS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLAT_DELAY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_RATIO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_RINV    = 3'd5;

  // classified command handed from front to back
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_HOME = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              sw;
    logic [MM_W-1:0]   mm;
  } cmd_t;

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_ACCEL  = 8'b0000_0010,
    PH_CRUISE = 8'b0000_0100,
    PH_DECEL  = 8'b0000_1000,
    PH_HACCEL = 8'b0001_0000,
    PH_HSEEK  = 8'b0010_0000,
    PH_HPAUSE = 8'b0100_0000,
    PH_HBACK  = 8'b1000_0000
  } phase_t;

endpackage

### sv/srpg_in_if.sv
interface srpg_in_if;
  import srpg_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [MM_W-1:0]   target_mm;
  logic              end_switch;
  modport source (output valid, func, target_mm, end_switch, input ready);
  modport sink   (input valid, func, target_mm, end_switch, output ready);
endinterface

### sv/srpg_out_if.sv
interface srpg_out_if;
  import srpg_pkg::*;
  logic                valid;
  logic                ready;
  logic                step_pulse;
  logic                direction;
  logic                motor_enable;
  logic                busy_res;
  logic [OUTPOS_W-1:0] position;
  modport source (output valid, step_pulse, direction, motor_enable, busy_res, position,
                  input ready);
  modport sink   (input valid, step_pulse, direction, motor_enable, busy_res, position,
                  output ready);
endinterface

### sv/srpg_cfg_if.sv
interface srpg_cfg_if;
  import srpg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/srpg_front.sv
module srpg_front (
  input  logic            clk,
  input  logic            rst_n,
  srpg_in_if.sink         in_ch,
  output logic            q_valid,
  input  logic            q_ready,
  output srpg_pkg::cmd_t  q_cmd
);
  import srpg_pkg::*;

  // two-entry queue between the input and the sequencer
  cmd_t       mem_r [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cls;

  // classify the incoming word
  always_comb begin
    cls.sw = in_ch.end_switch;
    cls.mm = in_ch.target_mm;
    unique case (in_ch.func)
      FUNC_TICK: cls.kind = CMD_TICK;
      FUNC_MOVE: cls.kind = CMD_MOVE;
      FUNC_HOME: cls.kind = CMD_HOME;
      default:   cls.kind = CMD_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_cmd   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // store the word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= cls;
    end
  end

  cnt_range_a: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  full_no_push_a: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !push) else $error("push into full queue");
  empty_ptr_a: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> (wptr_r == rptr_r)) else $error("pointers diverged on empty");

endmodule

### sv/srpg_back.sv
module srpg_back #(
  parameter int POSITION_BITS   = srpg_pkg::POSITION_BITS_DEF,
  parameter int DELAY_FRAC_BITS = srpg_pkg::DELAY_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  srpg_pkg::cmd_t  q_cmd,
  srpg_cfg_if.sink        cfg_ch,
  srpg_out_if.source      out_ch
);
  import srpg_pkg::*;

  localparam int PW   = POSITION_BITS;
  localparam int MW   = MM_W + SPM_W;           // mm * steps_per_mm width
  localparam int CW   = PW + 1;                 // step counters
  localparam logic [DELAY_W:0] ONE_TICK = (DELAY_W+1)'(64'd1 << DELAY_FRAC_BITS);
  localparam logic [DELAY_W-1:0] SAT = '1;

  // configuration
  logic [SPM_W-1:0]   spm_r;
  logic [RAMP_W-1:0]  ramp_r;
  logic [DELAY_W-1:0] sdel_r, fdel_r, ratio_r;
  logic [RINV_W-1:0]  rinv_r;

  // state
  phase_t             ph_r, ph_nxt;
  logic [PW-1:0]      pos_r, pos_nxt, tgt_r, tgt_nxt;
  logic               dir_r, dir_nxt, en_r, en_nxt;
  logic [CW-1:0]      left_r, left_nxt, cruise_r, cruise_nxt, rlen_r, rlen_nxt;
  logic [DELAY_W-1:0] spc_r, spc_nxt, wait_r, wait_nxt;

  // output register
  logic               ov_r;
  logic               pulse_r, pulse_nxt;

  // precomputed products, kept current with spacing and config
  logic [DELAY_W+RINV_W-1:0]  p_inv;
  logic [2*DELAY_W-1:0]       p_rat;
  logic [DELAY_W-1:0]         acc_spc, dec_spc;
  logic [MW-1:0]              tgt_raw;
  logic [PW-1:0]              tgt_sat, span;
  logic                       fire;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spm_r   <= SPM_W'(1);
      ramp_r  <= '0;
      sdel_r  <= DELAY_W'(65536000);
      fdel_r  <= DELAY_W'(65536000);
      ratio_r <= DELAY_W'(65536);
      rinv_r  <= RINV_W'(65536);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_STEPS_PER_MM: spm_r   <= cfg_ch.data[SPM_W-1:0];
        REG_RAMP_STEPS:   ramp_r  <= cfg_ch.data[RAMP_W-1:0];
        REG_START_DELAY:  sdel_r  <= cfg_ch.data;
        REG_FLAT_DELAY:   fdel_r  <= cfg_ch.data;
        REG_RAMP_RATIO:   ratio_r <= cfg_ch.data;
        REG_RAMP_RINV:    rinv_r  <= cfg_ch.data[RINV_W-1:0];
        default: ;
      endcase
    end
  end

  // scale spacing; scale factors are fixed point with 16 fraction bits: ratio Q16.16, rinv Q1.16
  assign p_inv = (DELAY_W+RINV_W)'(spc_r) * (DELAY_W+RINV_W)'(rinv_r);
  assign p_rat = (2*DELAY_W)'(spc_r) * (2*DELAY_W)'(ratio_r);
  assign acc_spc = (|p_inv[DELAY_W+RINV_W-1:DELAY_W+16]) ? SAT : p_inv[DELAY_W+15:16];
  assign dec_spc = (|p_rat[2*DELAY_W-1:DELAY_W+16]) ? SAT : p_rat[DELAY_W+15:16];

  // target conversion and distance
  assign tgt_raw = MW'(q_cmd.mm) * MW'(spm_r);
  always_comb begin
    if (MW > PW && (tgt_raw >> PW) != '0) tgt_sat = '1;
    else tgt_sat = PW'(tgt_raw);
  end
  assign span = (tgt_sat > pos_r) ? tgt_sat - pos_r : pos_r - tgt_sat;

  function automatic logic [DELAY_W-1:0] next_wait(input logic [DELAY_W-1:0] w,
                                                    input logic [DELAY_W-1:0] d);
    logic [DELAY_W:0] s;
    s = {1'b0, w} + {1'b0, d};
    s = (s >= ONE_TICK) ? s - ONE_TICK : '0;
    return s[DELAY_W] ? SAT : s[DELAY_W-1:0];
  endfunction

  // accept a command while the output slot is free or being drained
  assign q_ready = !ov_r || out_ch.ready;
  assign fire    = q_valid && q_ready;

  // sequencer
  always_comb begin
    ph_nxt = ph_r; pos_nxt = pos_r; tgt_nxt = tgt_r; dir_nxt = dir_r; en_nxt = en_r;
    left_nxt = left_r; cruise_nxt = cruise_r; rlen_nxt = rlen_r;
    spc_nxt = spc_r; wait_nxt = wait_r; pulse_nxt = 1'b0;
    if (fire) begin
      unique case (q_cmd.kind)
        CMD_MOVE: begin
          if (ph_r == PH_IDLE && tgt_sat != pos_r) begin
            dir_nxt = (tgt_sat < pos_r);
            if ({1'b0, span} <= CW'({ramp_r, 1'b0})) begin
              rlen_nxt   = CW'(span >> 1);
              cruise_nxt = CW'(span[0]);
            end else begin
              rlen_nxt   = CW'(ramp_r);
              cruise_nxt = CW'(span) - (CW'(ramp_r) << 1);
            end
            left_nxt = rlen_nxt;
            spc_nxt  = (ramp_r != '0) ? sdel_r : fdel_r;
            tgt_nxt  = tgt_sat;
            wait_nxt = '0;
            en_nxt   = 1'b1;
            ph_nxt   = PH_ACCEL;
          end
        end
        CMD_HOME: begin
          if (ph_r == PH_IDLE) begin
            dir_nxt  = 1'b1;
            en_nxt   = 1'b1;
            left_nxt = CW'(ramp_r);
            spc_nxt  = (ramp_r != '0) ? sdel_r : fdel_r;
            wait_nxt = '0;
            ph_nxt   = PH_HACCEL;
          end
        end
        CMD_TICK: begin
          if (ph_r == PH_IDLE) begin
            // nothing to do
          end else if ({1'b0, wait_r} >= ONE_TICK) begin
            wait_nxt = wait_r - DELAY_W'(ONE_TICK);
          end else begin
            unique case (ph_r)
              PH_ACCEL, PH_CRUISE, PH_DECEL: begin
                if (ph_r == PH_ACCEL && left_r != '0) begin
                  spc_nxt = acc_spc; left_nxt = left_r - CW'(1);
                  wait_nxt = next_wait(wait_r, acc_spc); pulse_nxt = 1'b1;
                end else if (ph_r != PH_DECEL && cruise_r != '0) begin
                  ph_nxt = PH_CRUISE; cruise_nxt = cruise_r - CW'(1);
                  wait_nxt = next_wait(wait_r, spc_r); pulse_nxt = 1'b1;
                end else if ((ph_r == PH_DECEL && left_r != '0) ||
                             (ph_r != PH_DECEL && rlen_r != '0)) begin
                  ph_nxt = PH_DECEL;
                  left_nxt = ((ph_r == PH_DECEL) ? left_r : rlen_r) - CW'(1);
                  spc_nxt = dec_spc;
                  wait_nxt = next_wait(wait_r, dec_spc); pulse_nxt = 1'b1;
                end else begin
                  if (ph_r != PH_DECEL) left_nxt = rlen_r;
                  pos_nxt = tgt_r; en_nxt = 1'b0; ph_nxt = PH_IDLE; wait_nxt = '0;
                end
              end
              PH_HACCEL, PH_HSEEK: begin
                if (q_cmd.sw) begin
                  ph_nxt = PH_HPAUSE; wait_nxt = next_wait(wait_r, sdel_r);
                end else if (ph_r == PH_HACCEL && left_r != '0) begin
                  spc_nxt = acc_spc; left_nxt = left_r - CW'(1);
                  wait_nxt = next_wait(wait_r, acc_spc); pulse_nxt = 1'b1;
                end else begin
                  ph_nxt = PH_HSEEK;
                  wait_nxt = next_wait(wait_r, spc_r); pulse_nxt = 1'b1;
                end
              end
              PH_HPAUSE, PH_HBACK: begin
                dir_nxt = 1'b0;
                ph_nxt  = PH_HBACK;
                if (q_cmd.sw) begin
                  spc_nxt = sdel_r;
                  wait_nxt = next_wait(wait_r, sdel_r); pulse_nxt = 1'b1;
                end else begin
                  pos_nxt = '0; en_nxt = 1'b0; ph_nxt = PH_IDLE; wait_nxt = '0;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; pos_r <= '0; tgt_r <= '0; dir_r <= 1'b0; en_r <= 1'b0;
      left_r <= '0; cruise_r <= '0; rlen_r <= '0; spc_r <= '0; wait_r <= '0;
      ov_r <= 1'b0; pulse_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; pos_r <= pos_nxt; tgt_r <= tgt_nxt; dir_r <= dir_nxt; en_r <= en_nxt;
      left_r <= left_nxt; cruise_r <= cruise_nxt; rlen_r <= rlen_nxt;
      spc_r <= spc_nxt; wait_r <= wait_nxt;
      if (fire) begin
        ov_r <= 1'b1; pulse_r <= pulse_nxt;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // result word reflects the state after the command
  assign out_ch.valid        = ov_r;
  assign out_ch.step_pulse   = pulse_r;
  assign out_ch.direction    = dir_r;
  assign out_ch.motor_enable = en_r;
  assign out_ch.busy_res     = (ph_r != PH_IDLE);
  assign out_ch.position     = OUTPOS_W'(pos_r);

  idle_disabled_a: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_IDLE) |-> !en_r) else $error("enable set while idle");
  pulse_busy_a: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && pulse_nxt) |=> (ph_r != PH_IDLE || $past(ph_r) != PH_IDLE))
    else $error("pulse without activity");
  hold_out_a: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> $stable(pulse_r) && ov_r) else $error("result lost");

endmodule

### sv/stepper_ramp_profile_generator.sv
// Stepper trapezoidal ramp generator.
// Channels: in_ch carries one word per tick, move or home command (func,
// target_mm, end_switch); out_ch returns exactly one result word per input
// word (step_pulse, direction, motor_enable, busy_res, position); cfg_ch
// writes the six ramp registers by index and is always ready.
// Path: an accepted word waits in the front queue and its result is held in
// the output register, after the results of the words ahead of it.
// Throughput: one word per cycle while out_ch.ready is high; the sequencer
// updates all state of one word in a single combinational step, so the
// two-entry front queue never stays full while out_ch keeps taking results.
// Stall: while out_ch.ready is low the result register holds, the sequencer
// stops and the front queue absorbs up to two more words before in_ch.ready
// drops.
// Reset: synchronous, active low; the generator is idle at position zero
// with registers at their reset values.
module stepper_ramp_profile_generator #(
  parameter int POSITION_BITS   = srpg_pkg::POSITION_BITS_DEF,
  parameter int DELAY_FRAC_BITS = srpg_pkg::DELAY_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  srpg_in_if.sink     in_ch,
  srpg_out_if.source  out_ch,
  srpg_cfg_if.sink    cfg_ch
);
  import srpg_pkg::*;

  logic q_valid, q_ready;
  cmd_t q_cmd;

  srpg_front u_front (
    .clk, .rst_n, .in_ch, .q_valid, .q_ready, .q_cmd
  );

  srpg_back #(
    .POSITION_BITS(POSITION_BITS), .DELAY_FRAC_BITS(DELAY_FRAC_BITS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .cfg_ch, .out_ch
  );

endmodule
